// ===== sv/signed_binary_to_decimal_ascii_macros.svh =====
// assertion macros for the signed binary to decimal ascii converter
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef SYNTHESIS
`define SBDA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBDA_ASSERT_IMPL(label, ante, cons)
`define SBDA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/sbda_pkg.sv =====
// shared constants, types and functions of the decimal ascii converter
package sbda_pkg;

    localparam int VALUE_W       = 64;
    localparam int VALUE_WIDTH   = 64;
    localparam int CHAR_W        = 6;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W         = STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(STEPS);
    // digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS    = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
    localparam int BCD_W         = NUM_DIGITS * 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CODE_NINE  = 6'd57;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } sbda_item_t;

    typedef struct packed {
        logic full;
        logic avail;
    } sbda_qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT
    } sbda_state_t;

    // one shift-add-3 step: correct every digit, then shift one bit in
    function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
        bcd_t           adj;
        logic [BCD_W:0] wide;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
        end
        wide = {adj, bit_in};
        return wide[BCD_W-1:0];
    endfunction

endpackage

// ===== sv/sbda_front.sv =====
// front end: accepts a value and splits it into sign and magnitude
module sbda_front
    import sbda_pkg::*;
(
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_stall,
    input  sbda_qstat_t               qstat,
    output logic                      push,
    output sbda_item_t                push_item
);

    logic [VALUE_WIDTH-1:0] x;

    assign x           = value[VALUE_WIDTH-1:0];
    assign value_stall = qstat.full;
    assign push        = value_valid && !qstat.full;

    always_comb
    begin
        push_item.neg = x[VALUE_WIDTH-1];
        // two's complement negate stays exact for the most negative value
        push_item.mag = x[VALUE_WIDTH-1] ? VALUE_WIDTH'(~x + VALUE_WIDTH'(1)) : x;
    end

endmodule

// ===== sv/sbda_queue.sv =====
// two-entry request queue between front end and converter
module sbda_queue
    import sbda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sbda_item_t  push_item,
    input  logic        pop,
    output sbda_item_t  pop_item,
    output sbda_qstat_t qstat
);

    sbda_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.avail = (count_reg != '0);
    assign pop_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/sbda_back.sv =====
// back end: shift-add-3 conversion and character output
module sbda_back
    import sbda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbda_qstat_t       qstat,
    input  sbda_item_t        pop_item,
    output logic              pop,
    output logic [CHAR_W-1:0] char_code,
    output logic              last,
    output logic              char_valid,
    input  logic              char_stall
);

    sbda_state_t           state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIG_IDX_W-1:0]  idx_reg, idx_next;
    logic [PAD_W-1:0]      shift_reg, shift_next;
    bcd_t                  bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  out_free;
    logic [DIG_IDX_W-1:0]  top_idx;

    assign out_free   = !out_valid_reg || !char_stall;
    assign char_code  = char_reg;
    assign last       = last_reg;
    assign char_valid = out_valid_reg;

    // highest nonzero digit, zero gives the lowest digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = DIG_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (qstat.avail)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == STEP_CNT_W'(STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free && idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bcd_t             b;
        logic [PAD_W-1:0] s;
        pop            = 1'b0;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && char_stall;
        b              = bcd_reg;
        s              = shift_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (qstat.avail)
                begin
                    pop        = 1'b1;
                    neg_next   = pop_item.neg;
                    shift_next = PAD_W'(pop_item.mag);
                    bcd_next   = '0;
                    cnt_next   = '0;
                end
            end
            ST_CONV:
            begin
                for (int k = 0; k < BITS_PER_STEP; k++)
                begin
                    b = dabble_step(b, s[PAD_W-1]);
                    s = {s[PAD_W-2:0], 1'b0};
                end
                bcd_next   = b;
                shift_next = s;
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_SCAN:
            begin
                idx_next = top_idx;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CODE_MINUS;
                    last_next      = 1'b0;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CODE_ZERO + {2'b00, bcd_reg[idx_reg]};
                    last_next      = (idx_reg == '0);
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII converter. Each accepted value (two's complement, low
// VALUE_WIDTH bits used) comes out as its decimal text, one character per request on the
// output channel, minus sign first for negative values, no leading zeros, and last set on
// the final character. A two-entry queue holds waiting values in front of the converter.
// Each value is picked from the queue, then goes through 16 steps of the shift-add-3 loop,
// which takes 4 magnitude bits per cycle, then the leading digit is found, and then one
// character (1 to 20 in all) is sent per cycle while the output is not stalled.
`include "signed_binary_to_decimal_ascii_macros.svh"
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_stall,
    output logic [CHAR_W-1:0]         char_code,
    output logic                      last,
    output logic                      char_valid,
    input  logic                      char_stall
);

    sbda_qstat_t qstat;
    sbda_item_t  push_item;
    sbda_item_t  pop_item;
    logic        push;
    logic        pop;

    sbda_front u_front (
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .qstat       (qstat),
        .push        (push),
        .push_item   (push_item)
    );

    sbda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    sbda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .pop_item   (pop_item),
        .pop        (pop),
        .char_code  (char_code),
        .last       (last),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

    `SBDA_ASSERT_IMPL(a_pop_needs_item, pop, qstat.avail)
    `SBDA_ASSERT_IMPL(a_char_legal, char_valid,
        (char_code == CODE_MINUS) || ((char_code >= CODE_ZERO) && (char_code <= CODE_NINE)))
    `SBDA_ASSERT_IMPL(a_minus_not_last, char_valid && (char_code == CODE_MINUS), !last)
    `SBDA_ASSERT_IMPL(a_no_pop_while_emitting, char_valid && !last, !pop)

endmodule
